@@ hw/rtl/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants and types for the fixed-point 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

   localparam int MM_DIM       = 4;
   localparam int MM_FRAC_BITS = 16;
   localparam int VALUE_W      = 32;
   localparam int PROD_W       = 2 * VALUE_W;
   localparam int CMDQ_DEPTH   = 2;

   localparam logic signed [VALUE_W-1:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic empty;
      logic full;
   } cmdq_status_type;

endpackage

@@ hw/rtl/mat4_multiply.sv @@
// ----------------------------------------------------------------------------
// mat4_multiply
// Streaming signed fixed-point matrix product: loads both operands, then
// emits every element of left times right in column-major order.
// Loading takes one item per cycle while req_stall is low. After the item
// marked last, a start command passes through the command queue; then, for
// each element, a single multiply-accumulate takes one operand pair per
// cycle from one read port of each store, then the pipeline drains.
// No new item is taken until the last result of a product is registered.
// Reset clears the load position, the command queue, the sequencer and the
// output valid; the element stores keep their contents.
// ----------------------------------------------------------------------------
module mat4_multiply
   import mm4_pkg::*;
#(
   parameter int DIM       = MM_DIM,
   parameter int FRAC_BITS = MM_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [VALUE_W-1:0]         req_left_value,
   input  logic signed [VALUE_W-1:0]         req_right_value,
   input  logic                              req_load_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [VALUE_W-1:0]         rsp_product_value,
   output logic [$clog2(DIM*DIM)-1:0]        rsp_product_index,
   output logic                              rsp_overflow_flag,
   output logic                              rsp_result_last
);

   localparam int IDX_W = $clog2(DIM * DIM);

   cmdq_status_type           cmdq_status;
   logic                      cmdq_push;
   logic                      cmdq_pop;
   logic                      back_busy;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [VALUE_W-1:0] wr_left;
   logic signed [VALUE_W-1:0] wr_right;
   logic [IDX_W-1:0]          rd_left_addr;
   logic [IDX_W-1:0]          rd_right_addr;
   logic signed [VALUE_W-1:0] left_rd;
   logic signed [VALUE_W-1:0] right_rd;

   mm4_front #(
      .DIM (DIM)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_value  (req_left_value),
      .req_right_value (req_right_value),
      .req_load_last   (req_load_last),
      .back_busy       (back_busy),
      .cmdq_status     (cmdq_status),
      .cmdq_push       (cmdq_push),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_left         (wr_left),
      .wr_right        (wr_right)
   );

   mm4_cmdq u_cmdq (
      .clock  (clock),
      .reset  (reset),
      .push   (cmdq_push),
      .pop    (cmdq_pop),
      .status (cmdq_status)
   );

   mm4_store #(
      .DIM (DIM)
   ) u_store (
      .clock         (clock),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_left       (wr_left),
      .wr_right      (wr_right),
      .rd_left_addr  (rd_left_addr),
      .rd_right_addr (rd_right_addr),
      .left_rd       (left_rd),
      .right_rd      (right_rd)
   );

   mm4_back #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmdq_status       (cmdq_status),
      .cmdq_pop          (cmdq_pop),
      .busy              (back_busy),
      .rd_left_addr      (rd_left_addr),
      .rd_right_addr     (rd_right_addr),
      .left_rd           (left_rd),
      .right_rd          (right_rd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_product_index (rsp_product_index),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_result_last   (rsp_result_last)
   );

   a_no_write_while_reading : assert property (@(posedge clock) disable iff (reset)
      back_busy |-> !wr_en)
      else $error("store written during a product");

endmodule

@@ hw/rtl/mm4_cmdq.sv @@
// ----------------------------------------------------------------------------
// mm4_cmdq
// Short token queue of product start commands between front and back.
// ----------------------------------------------------------------------------
module mm4_cmdq
   import mm4_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  logic            pop,
   output cmdq_status_type status
);

   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(CMDQ_DEPTH));

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !status.full)
      else $error("command queue overflow");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("command queue underflow");

endmodule

@@ hw/rtl/mm4_front.sv @@
// ----------------------------------------------------------------------------
// mm4_front
// Takes element pairs, writes them to the stores and queues a product start
// on the item marked last.
// ----------------------------------------------------------------------------
module mm4_front
   import mm4_pkg::*;
#(
   parameter int DIM = MM_DIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [VALUE_W-1:0]         req_left_value,
   input  logic signed [VALUE_W-1:0]         req_right_value,
   input  logic                              req_load_last,
   input  logic                              back_busy,
   input  cmdq_status_type                   cmdq_status,
   output logic                              cmdq_push,
   output logic                              wr_en,
   output logic [$clog2(DIM*DIM)-1:0]        wr_addr,
   output logic signed [VALUE_W-1:0]         wr_left,
   output logic signed [VALUE_W-1:0]         wr_right
);

   localparam int CELLS = DIM * DIM;
   localparam int IDX_W = $clog2(CELLS);

   logic [IDX_W-1:0] load_count_ff;
   logic             accept;

   // stores stay untouched while a product is pending or being read
   assign req_stall = back_busy || !cmdq_status.empty || cmdq_status.full;
   assign accept    = req_valid && !req_stall;

   assign wr_en     = accept;
   assign wr_addr   = load_count_ff;
   assign wr_left   = req_left_value;
   assign wr_right  = req_right_value;
   assign cmdq_push = accept && req_load_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else if (accept) begin
         if (req_load_last || load_count_ff == IDX_W'(CELLS - 1)) begin
            load_count_ff <= '0;
         end else begin
            load_count_ff <= load_count_ff + IDX_W'(1);
         end
      end
   end

endmodule

@@ hw/rtl/mm4_store.sv @@
// ----------------------------------------------------------------------------
// mm4_store
// Left and right element memories: one write port, one registered read each.
// ----------------------------------------------------------------------------
module mm4_store
   import mm4_pkg::*;
#(
   parameter int DIM = MM_DIM
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DIM*DIM)-1:0]        wr_addr,
   input  logic signed [VALUE_W-1:0]         wr_left,
   input  logic signed [VALUE_W-1:0]         wr_right,
   input  logic [$clog2(DIM*DIM)-1:0]        rd_left_addr,
   input  logic [$clog2(DIM*DIM)-1:0]        rd_right_addr,
   output logic signed [VALUE_W-1:0]         left_rd,
   output logic signed [VALUE_W-1:0]         right_rd
);

   localparam int CELLS = DIM * DIM;

   logic signed [VALUE_W-1:0] left_store_ff  [CELLS];
   logic signed [VALUE_W-1:0] right_store_ff [CELLS];
   logic signed [VALUE_W-1:0] left_rd_ff;
   logic signed [VALUE_W-1:0] right_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_store_ff[wr_addr]  <= wr_left;
         right_store_ff[wr_addr] <= wr_right;
      end
      left_rd_ff  <= left_store_ff[rd_left_addr];
      right_rd_ff <= right_store_ff[rd_right_addr];
   end

   assign left_rd  = left_rd_ff;
   assign right_rd = right_rd_ff;

endmodule

@@ hw/rtl/mm4_back.sv @@
// ----------------------------------------------------------------------------
// mm4_back
// Product sequencer: one shared multiply-accumulate walks every dot product,
// then shifts, saturates and hands the element to the output register.
// ----------------------------------------------------------------------------
module mm4_back
   import mm4_pkg::*;
#(
   parameter int DIM       = MM_DIM,
   parameter int FRAC_BITS = MM_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cmdq_status_type                   cmdq_status,
   output logic                              cmdq_pop,
   output logic                              busy,
   output logic [$clog2(DIM*DIM)-1:0]        rd_left_addr,
   output logic [$clog2(DIM*DIM)-1:0]        rd_right_addr,
   input  logic signed [VALUE_W-1:0]         left_rd,
   input  logic signed [VALUE_W-1:0]         right_rd,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [VALUE_W-1:0]         rsp_product_value,
   output logic [$clog2(DIM*DIM)-1:0]        rsp_product_index,
   output logic                              rsp_overflow_flag,
   output logic                              rsp_result_last
);

   localparam int CELLS = DIM * DIM;
   localparam int IDX_W = $clog2(CELLS);
   localparam int DIM_W = $clog2(DIM);
   localparam int ACC_W = PROD_W + $clog2(DIM);

   typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN} state_type;

   state_type                 state_ff;
   logic [DIM_W-1:0]          row_ff;
   logic [DIM_W-1:0]          col_ff;
   logic [DIM_W-1:0]          k_ff;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [IDX_W-1:0]          rsp_index_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_last_ff;

   logic                      rd_vld_ff;
   logic                      rd_last_ff;
   logic                      prod_vld_ff;
   logic                      prod_last_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      sum_done_ff;

   logic                      issue;
   logic                      k_last;
   logic                      elem_last;
   logic                      out_free;
   logic                      finish;
   logic                      acc_clr;
   logic signed [ACC_W-1:0]   shifted;
   logic [ACC_W-VALUE_W:0]    shifted_hi;
   logic                      fits;
   logic signed [VALUE_W-1:0] sat_value;

   assign issue     = (state_ff == ST_MAC);
   assign k_last    = (k_ff == DIM_W'(DIM - 1));
   assign elem_last = (row_ff == DIM_W'(DIM - 1)) && (col_ff == DIM_W'(DIM - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_DRAIN) && sum_done_ff && out_free;
   assign cmdq_pop  = (state_ff == ST_IDLE) && !cmdq_status.empty;
   assign acc_clr   = cmdq_pop || finish;
   assign busy      = (state_ff != ST_IDLE);

   // left walks a row, right walks a column, both column-major
   assign rd_left_addr  = IDX_W'(row_ff) + IDX_W'(k_ff) * IDX_W'(DIM);
   assign rd_right_addr = IDX_W'(k_ff) + IDX_W'(col_ff) * IDX_W'(DIM);

   // arithmetic shift floors; saturate when the upper bits are not all sign
   assign shifted    = acc_ff >>> FRAC_BITS;
   assign shifted_hi = shifted[ACC_W-1:VALUE_W-1];
   assign fits       = (&shifted_hi) || !(|shifted_hi);
   assign sat_value  = fits ? shifted[VALUE_W-1:0]
                            : (acc_ff[ACC_W-1] ? SAT_MIN : SAT_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
      end else begin
         if (!rsp_stall && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmdq_pop) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (k_last) begin
                  k_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  k_ff <= k_ff + DIM_W'(1);
               end
            end
            ST_DRAIN: begin
               if (finish) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= sat_value;
                  rsp_ovf_ff   <= !fits;
                  rsp_index_ff <= IDX_W'(row_ff) + IDX_W'(col_ff) * IDX_W'(DIM);
                  rsp_last_ff  <= elem_last;
                  if (elem_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     if (row_ff == DIM_W'(DIM - 1)) begin
                        row_ff <= '0;
                        col_ff <= col_ff + DIM_W'(1);
                     end else begin
                        row_ff <= row_ff + DIM_W'(1);
                     end
                     state_ff <= ST_MAC;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         sum_done_ff  <= 1'b0;
      end else begin
         rd_vld_ff    <= issue;
         rd_last_ff   <= issue && k_last;
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_last_ff;
         if (acc_clr) begin
            sum_done_ff <= 1'b0;
         end else if (prod_vld_ff && prod_last_ff) begin
            sum_done_ff <= 1'b1;
         end
      end
      prod_ff <= left_rd * right_rd;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_product_index = rsp_index_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;
   assign rsp_result_last   = rsp_last_ff;

   a_done_in_drain : assert property (@(posedge clock) disable iff (reset)
      sum_done_ff |-> state_ff == ST_DRAIN)
      else $error("dot product finished outside drain");

   a_pop_starts : assert property (@(posedge clock) disable iff (reset)
      cmdq_pop |=> state_ff == ST_MAC && row_ff == '0 && col_ff == '0)
      else $error("product start did not enter accumulation");

   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_last |-> rsp_product_index == IDX_W'(CELLS - 1))
      else $error("last flag on wrong element");

endmodule
